@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ETS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ets_pkg.sv @@
`default_nettype none

package ets_pkg;

    // fixed field widths
    localparam int CNT_W  = 7;
    localparam int X_W    = 6;
    localparam int SUM_W  = 64;

    // internal exact term and accumulator width
    localparam int ACC_W  = 128;
    // divisor is below 64, so the partial remainder fits one bit less than the index
    localparam int REM_W  = CNT_W - 1;
    // two quotient bits per division step
    localparam int DIV_STEPS = ACC_W / 2;
    localparam int LC_W   = $clog2(DIV_STEPS);
    localparam int XB_W   = $clog2(X_W);

    localparam int DEF_MAX_TERMS = 64;
    localparam int DEF_FRAC_BITS = 32;

    localparam int UPC_W = 4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TERM,
        OP_ACC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_DONE,
        JC_FIRST,
        JC_LOOP,
        JC_OUT_BUSY
    } jc_t;

    typedef struct packed {
        dp_op_t             op;
        jc_t                cond;
        logic [UPC_W-1:0]   target;
    } uc_word_t;

    typedef struct packed {
        logic done;
        logic first;
        logic loop_nz;
    } ets_flags_t;

    // microprogram step addresses
    localparam logic [UPC_W-1:0] ST_WAIT  = 4'd0;
    localparam logic [UPC_W-1:0] ST_CHECK = 4'd1;
    localparam logic [UPC_W-1:0] ST_FIRST = 4'd2;
    localparam logic [UPC_W-1:0] ST_MULI  = 4'd3;
    localparam logic [UPC_W-1:0] ST_MULS  = 4'd4;
    localparam logic [UPC_W-1:0] ST_DIVI  = 4'd5;
    localparam logic [UPC_W-1:0] ST_DIVS  = 4'd6;
    localparam logic [UPC_W-1:0] ST_TERM  = 4'd7;
    localparam logic [UPC_W-1:0] ST_ACC   = 4'd8;
    localparam logic [UPC_W-1:0] ST_HOLD  = 4'd9;
    localparam logic [UPC_W-1:0] ST_OUT   = 4'd10;

    function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] addr);
        uc_word_t w;
        begin
            w = '{op: OP_NONE, cond: JC_ALWAYS, target: ST_WAIT};
            case (addr)
                ST_WAIT:  w = '{op: OP_LOAD,      cond: JC_NO_INPUT, target: ST_WAIT};
                ST_CHECK: w = '{op: OP_NONE,      cond: JC_DONE,     target: ST_HOLD};
                ST_FIRST: w = '{op: OP_NONE,      cond: JC_FIRST,    target: ST_ACC};
                ST_MULI:  w = '{op: OP_MUL_INIT,  cond: JC_NEXT,     target: ST_WAIT};
                ST_MULS:  w = '{op: OP_MUL_STEP,  cond: JC_LOOP,     target: ST_MULS};
                ST_DIVI:  w = '{op: OP_DIV_INIT,  cond: JC_NEXT,     target: ST_WAIT};
                ST_DIVS:  w = '{op: OP_DIV_STEP,  cond: JC_LOOP,     target: ST_DIVS};
                ST_TERM:  w = '{op: OP_TERM,      cond: JC_NEXT,     target: ST_WAIT};
                ST_ACC:   w = '{op: OP_ACC,       cond: JC_ALWAYS,   target: ST_CHECK};
                ST_HOLD:  w = '{op: OP_NONE,      cond: JC_OUT_BUSY, target: ST_HOLD};
                ST_OUT:   w = '{op: OP_OUT,       cond: JC_ALWAYS,   target: ST_WAIT};
                default:  w = '{op: OP_NONE,      cond: JC_ALWAYS,   target: ST_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/exp_taylor_series_sum.sv @@
// an accepted transaction loads the operands, then each term is built and added
//   up to the term count (clamped to MAX_TERMS), then the sum is written out
// each later term: 6 shift-add multiply, 64 two-bit division and 6 control steps
// a new transaction is taken only once the last result is written out; a result waits
//   in the output register while the next transaction is taken
// reset: asynchronous active low, clears the step counter and output valid
`default_nettype none

module exp_taylor_series_sum
    import ets_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [CNT_W-1:0]       term_count,
    input  wire logic signed [X_W-1:0]  x_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [SUM_W-1:0]     series_sum
);

    dp_op_t           op;
    ets_flags_t       flags;
    logic [SUM_W-1:0] sat_sum;
    logic             out_busy;
    logic             out_valid_reg;
    logic [SUM_W-1:0] sum_reg;

    assign out_busy = out_valid_reg && !out_ready;

    ets_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .op       (op),
        .in_ready (in_ready)
    );

    ets_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .term_count (term_count),
        .x_value    (x_value),
        .flags      (flags),
        .sat_sum    (sat_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_OUT)
        begin
            sum_reg <= sat_sum;
        end
    end

    assign out_valid  = out_valid_reg;
    assign series_sum = $signed(sum_reg);

endmodule

`default_nettype wire

@@ design/ets_sequencer.sv @@
`default_nettype none

`include "assert_macros.svh"

module ets_sequencer
    import ets_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       out_busy,
    input  wire ets_flags_t flags,
    output dp_op_t          op,
    output logic            in_ready
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uc_word_t         cw;
    logic             take;

    always_comb
    begin
        cw = uc_rom(upc_reg);
        case (cw.cond)
            JC_NEXT:     take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_NO_INPUT: take = !in_valid;
            JC_DONE:     take = flags.done;
            JC_FIRST:    take = flags.first;
            JC_LOOP:     take = flags.loop_nz;
            JC_OUT_BUSY: take = out_busy;
            default:     take = 1'b1;
        endcase
        upc_next = take ? cw.target : upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign op       = cw.op;
    assign in_ready = (upc_reg == ST_WAIT);

    `ETS_ASSERT_IMP(a_upc_range, 1'b1, upc_reg <= ST_OUT, "step counter off the program")
    `ETS_ASSERT_IMP(a_out_free, op == OP_OUT, !out_busy, "result written over a waiting one")
    `ETS_ASSERT_NXT(a_accept_go, in_valid && in_ready, upc_reg == ST_CHECK,
        "accepted transaction did not start the program")
    `ETS_ASSERT_IMP(a_div_nonzero, upc_reg == ST_DIVS, !flags.first, "division by term index zero")

endmodule

`default_nettype wire

@@ design/ets_datapath.sv @@
`default_nettype none

module ets_datapath
    import ets_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_op_t                 op,
    input  wire logic [CNT_W-1:0]       term_count,
    input  wire logic signed [X_W-1:0]  x_value,
    output ets_flags_t                  flags,
    output logic [SUM_W-1:0]            sat_sum
);

    logic [ACC_W-1:0] term_reg, term_next;
    logic [ACC_W-1:0] acc_reg,  acc_next;
    logic [ACC_W-1:0] work_reg, work_next;
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [CNT_W-1:0] idx_reg,  idx_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [LC_W-1:0]  lc_reg,   lc_next;
    logic [X_W-1:0]   xmag_reg, xmag_next;
    logic             xneg_reg, xneg_next;

    logic [X_W-1:0]   x_u;
    logic [CNT_W-1:0] r1, r1s, r2, r2s;
    logic             ge1, ge2;
    logic             upper_ones, upper_zeros;

    always_comb
    begin
        x_u = $unsigned(x_value);

        // two restoring division bits per step, dividend shifts out of work
        r1  = {rem_reg, work_reg[ACC_W-1]};
        ge1 = (r1 >= idx_reg);
        r1s = ge1 ? r1 - idx_reg : r1;
        r2  = {r1s[REM_W-1:0], work_reg[ACC_W-2]};
        ge2 = (r2 >= idx_reg);
        r2s = ge2 ? r2 - idx_reg : r2;

        term_next = term_reg;
        acc_next  = acc_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        lc_next   = lc_reg;
        xmag_next = xmag_reg;
        xneg_next = xneg_reg;

        case (op)
            OP_LOAD:
            begin
                term_next = ACC_W'(1) << FRAC_BITS;
                acc_next  = '0;
                idx_next  = '0;
                cnt_next  = (term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count;
                xneg_next = x_value[X_W-1];
                xmag_next = x_value[X_W-1] ? (~x_u + 1'b1) : x_u;
            end
            OP_MUL_INIT:
            begin
                work_next = '0;
                lc_next   = LC_W'(X_W - 1);
            end
            OP_MUL_STEP:
            begin
                // msb-first shift and add over the bits of |x|
                work_next = {work_reg[ACC_W-2:0], 1'b0}
                          + (xmag_reg[lc_reg[XB_W-1:0]] ? term_reg : '0);
                lc_next   = lc_reg - 1'b1;
            end
            OP_DIV_INIT:
            begin
                rem_next = '0;
                lc_next  = LC_W'(DIV_STEPS - 1);
            end
            OP_DIV_STEP:
            begin
                work_next = {work_reg[ACC_W-3:0], ge1, ge2};
                rem_next  = r2s[REM_W-1:0];
                lc_next   = lc_reg - 1'b1;
            end
            OP_TERM:
            begin
                term_next = work_reg;
            end
            OP_ACC:
            begin
                // odd terms of a negative exponent are subtracted
                if (xneg_reg && idx_reg[0])
                begin
                    acc_next = acc_reg - term_reg;
                end
                else
                begin
                    acc_next = acc_reg + term_reg;
                end
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
            lc_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            lc_reg  <= lc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        acc_reg  <= acc_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        xmag_reg <= xmag_next;
        xneg_reg <= xneg_next;
    end

    always_comb
    begin
        flags.done    = (idx_reg == cnt_reg);
        flags.first   = (idx_reg == '0);
        flags.loop_nz = (lc_reg != '0);

        // saturate unless the top bits are all sign
        upper_ones  = &acc_reg[ACC_W-1:SUM_W-1];
        upper_zeros = ~|acc_reg[ACC_W-1:SUM_W-1];
        if (upper_ones || upper_zeros)
        begin
            sat_sum = acc_reg[SUM_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire
